@@ design/kap_pkg.sv @@
`timescale 1ns / 1ps
package kap_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_STOPS_DEF      = 16;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int POS_W    = 17;
    localparam int COEF_W   = 32;
    localparam int SLOT_W   = 4;
    localparam int CNT_CFG_W = 5;
    localparam int STATUS_W = 2;
    localparam int COEFS_PER_STOP = 6;

    // Position fraction bits (Q1.16) and one
    localparam int POS_FRAC = 16;
    localparam logic [POS_W-1:0] POS_ONE = 17'h10000;

    // Divider: ((pos - off_l) << 16) / span
    localparam int DIV_NUM_W = POS_W + POS_FRAC;
    localparam int DIV_DEN_W = POS_W;

    // Matrix product accumulator (two 64-bit products plus translation)
    localparam int ACC_W = 67;

    localparam logic [CNT_CFG_W-1:0] STOP_COUNT_RESET = 5'd2;

    // Opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XFORM = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ORDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SLOT  = 2'd2;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } kap_div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } kap_div_rsp_t;

endpackage

@@ design/kap_ram.sv @@
`timescale 1ns / 1ps
module kap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/kap_div.sv @@
`timescale 1ns / 1ps
module kap_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  kap_pkg::kap_div_req_t req,
    output kap_pkg::kap_div_rsp_t rsp
);
    import kap_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   trial;

    // Restoring division, one quotient bit per cycle
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIV_NUM_W-1]};
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DIV_DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_DEN_W-1:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

@@ design/keyframed_affine_point_transform_core.sv @@
`timescale 1ns / 1ps
// Keyframed affine point transform. A stop table holds up to MAX_STOPS stops,
// each a Q1.16 offset and a 2x3 Q16.16 matrix, kept in two RAMs with one write
// port and one registered read port each, plus per-stop valid bits (unwritten
// stops read as zero, no clearing pass).
// Items are handled one at a time. A load does one offset read for the order
// check, then six coefficient writes. A transform between stops walks the
// stop search over the offsets, runs the bit-serial divider for the fraction,
// reads the left and right value of each coefficient on the single coefficient
// read port, and multiplies and accumulates the two output rows. A position at
// or beyond either end skips the search and divider. The result waits in an
// output register, so the next item is taken meanwhile.
module keyframed_affine_point_transform_core #(
    parameter int MAX_STOPS      = kap_pkg::MAX_STOPS_DEF,
    parameter int COEF_FRAC_BITS = kap_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration: stop_count
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kap_pkg::CNT_CFG_W-1:0]  cfg_data,
    // Input: slot[3:0], position[20:4], coef_scale_x[52:21],
    // coef_shear_y[84:53], coef_shear_x[116:85], coef_scale_y[148:117],
    // coef_move_x[180:149], coef_move_y[212:181], point_x[244:213],
    // point_y[276:245], zero fill [279:277]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [279:0]                   s_tdata,
    // opcode[0]
    input  logic                           s_tuser,
    // Output: out_x[31:0], out_y[63:32], status[65:64], zero fill [71:66]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [71:0]                    m_tdata
);
    import kap_pkg::*;

    localparam int IDX_W = $clog2(MAX_STOPS);
    localparam int CNT_W = $clog2(MAX_STOPS + 1);
    localparam int CA_W  = $clog2(MAX_STOPS * COEFS_PER_STOP);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_LDA  = 5'd1;
    localparam logic [4:0] S_LDB  = 5'd2;
    localparam logic [4:0] S_LDW  = 5'd3;
    localparam logic [4:0] S_TR0  = 5'd4;
    localparam logic [4:0] S_TR1  = 5'd5;
    localparam logic [4:0] S_TR2  = 5'd6;
    localparam logic [4:0] S_SLA  = 5'd7;
    localparam logic [4:0] S_SLB  = 5'd8;
    localparam logic [4:0] S_SRA  = 5'd9;
    localparam logic [4:0] S_SRB  = 5'd10;
    localparam logic [4:0] S_CHK  = 5'd11;
    localparam logic [4:0] S_DIV  = 5'd12;
    localparam logic [4:0] S_CRL  = 5'd13;
    localparam logic [4:0] S_CRR  = 5'd14;
    localparam logic [4:0] S_CDF  = 5'd15;
    localparam logic [4:0] S_CMUL = 5'd16;
    localparam logic [4:0] S_CADD = 5'd17;
    localparam logic [4:0] S_APT  = 5'd18;
    localparam logic [4:0] S_APA  = 5'd19;
    localparam logic [4:0] S_APS  = 5'd20;
    localparam logic [4:0] S_FIN  = 5'd21;

    // Control and configuration registers
    logic [4:0]           state_reg, state_next;
    logic [CNT_CFG_W-1:0] stop_count_reg;
    logic [MAX_STOPS-1:0] valid_reg, valid_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 off_vld_q_reg, coef_vld_q_reg;

    // Item registers
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [COEF_W-1:0]    cin_reg [COEFS_PER_STOP];
    logic [COEF_W-1:0]    cin_next [COEFS_PER_STOP];
    logic [COEF_W-1:0]    px_reg, px_next, py_reg, py_next;

    // Search, interpolation and apply registers
    logic [IDX_W-1:0]     left_reg, left_next;
    logic [CNT_W-1:0]     right_reg, right_next;
    logic [POS_W-1:0]     offl_reg, offl_next, offr_reg, offr_next;
    logic [POS_W-1:0]     frac_reg, frac_next;
    logic [2:0]           ci_reg, ci_next;
    logic [COEF_W-1:0]    coefl_reg, coefl_next;
    logic [COEF_W:0]      diff_reg, diff_next;
    logic [COEF_W+POS_W:0] iprod_reg, iprod_next;
    logic [COEF_W-1:0]    m_reg [COEFS_PER_STOP];
    logic [COEF_W-1:0]    m_next [COEFS_PER_STOP];
    logic                 row_reg, row_next;
    logic [1:0]           term_reg, term_next;
    logic [2*COEF_W-1:0]  pprod_reg, pprod_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [COEF_W-1:0]    rx_reg, rx_next, ry_reg, ry_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    // Output register
    logic [COEF_W-1:0]    out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [STATUS_W-1:0]  out_st_reg, out_st_next;

    // RAM ports
    logic                 off_we;
    logic [IDX_W-1:0]     off_waddr, off_raddr;
    logic [POS_W-1:0]     off_wdata, off_rdata, off_q;
    logic                 coef_we;
    logic [CA_W-1:0]      coef_waddr, coef_raddr;
    logic [COEF_W-1:0]    coef_wdata, coef_rdata, coef_q;
    logic [IDX_W-1:0]     coef_stop;

    kap_div_req_t         div_req;
    kap_div_rsp_t         div_rsp;

    logic [CNT_W-1:0]     n_used;
    logic [IDX_W-1:0]     last_idx, slot_idx;
    logic [POS_W-1:0]     pos_sat;
    logic                 s_xfer;
    logic [COEF_W-1:0]    mul_a, mul_b, row_t;
    logic [ACC_W-1:0]     acc_sh;
    logic [COEF_W-1:0]    sat_val;

    kap_ram #(.WIDTH(POS_W), .DEPTH(MAX_STOPS)) u_off_ram (
        .aclk  (aclk),
        .we    (off_we),
        .waddr (off_waddr),
        .wdata (off_wdata),
        .raddr (off_raddr),
        .rdata (off_rdata)
    );

    kap_ram #(.WIDTH(COEF_W), .DEPTH(MAX_STOPS * COEFS_PER_STOP)) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    kap_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Stop count in use, clamped to 2..MAX_STOPS
    always_comb begin
        if (stop_count_reg < CNT_CFG_W'(2)) begin
            n_used = CNT_W'(2);
        end else if (32'(stop_count_reg) > MAX_STOPS) begin
            n_used = CNT_W'(MAX_STOPS);
        end else begin
            n_used = CNT_W'(stop_count_reg);
        end
    end

    assign last_idx = IDX_W'(n_used - 1'b1);
    assign slot_idx = IDX_W'(slot_reg);
    assign pos_sat  = (pos_reg > POS_ONE) ? POS_ONE : pos_reg;
    assign off_q    = off_vld_q_reg ? off_rdata : '0;
    assign coef_q   = coef_vld_q_reg ? coef_rdata : '0;
    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Apply operands for the current row and term
    assign mul_a  = (term_reg == 2'd0) ? m_reg[row_reg ? 1 : 0] : m_reg[row_reg ? 3 : 2];
    assign mul_b  = (term_reg == 2'd0) ? px_reg : py_reg;
    assign row_t  = m_reg[row_reg ? 5 : 4];
    assign acc_sh = $signed(acc_reg) >>> COEF_FRAC_BITS;

    // Saturate the floored row sum to 32 bits
    always_comb begin
        if ($signed(acc_sh) > $signed({{(ACC_W-COEF_W){1'b0}}, 32'h7fffffff})) begin
            sat_val = 32'h7fffffff;
        end else if ($signed(acc_sh) < $signed({{(ACC_W-COEF_W){1'b1}}, 32'h80000000})) begin
            sat_val = 32'h80000000;
        end else begin
            sat_val = acc_sh[COEF_W-1:0];
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        m_valid_next = m_valid_reg && !m_tready;
        slot_next    = slot_reg;
        pos_next     = pos_reg;
        cin_next     = cin_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        offl_next    = offl_reg;
        offr_next    = offr_reg;
        frac_next    = frac_reg;
        ci_next      = ci_reg;
        coefl_next   = coefl_reg;
        diff_next    = diff_reg;
        iprod_next   = iprod_reg;
        m_next       = m_reg;
        row_next     = row_reg;
        term_next    = term_reg;
        pprod_next   = pprod_reg;
        acc_next     = acc_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        status_next  = status_reg;
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        out_st_next  = out_st_reg;
        off_we       = 1'b0;
        off_waddr    = slot_idx;
        off_wdata    = pos_sat;
        off_raddr    = '0;
        coef_we      = 1'b0;
        coef_waddr   = CA_W'(32'(slot_idx) * COEFS_PER_STOP + 32'(ci_reg));
        coef_wdata   = cin_reg[ci_reg];
        coef_raddr   = '0;
        coef_stop    = '0;
        div_req.start = 1'b0;
        div_req.num   = {pos_reg - offl_reg, {POS_FRAC{1'b0}}};
        div_req.den   = offr_reg - offl_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    slot_next   = s_tdata[3:0];
                    pos_next    = s_tdata[20:4];
                    cin_next[0] = s_tdata[52:21];
                    cin_next[1] = s_tdata[84:53];
                    cin_next[2] = s_tdata[116:85];
                    cin_next[3] = s_tdata[148:117];
                    cin_next[4] = s_tdata[180:149];
                    cin_next[5] = s_tdata[212:181];
                    px_next     = s_tdata[244:213];
                    py_next     = s_tdata[276:245];
                    state_next  = (s_tuser == OP_LOAD) ? S_LDA : S_TR0;
                end
            end
            // Load: slot check, then read the previous offset
            S_LDA: begin
                rx_next = '0;
                ry_next = '0;
                if ({1'b0, slot_reg} >= 5'(n_used)) begin
                    status_next = ST_SLOT;
                    state_next  = S_FIN;
                end else begin
                    off_raddr  = slot_idx - 1'b1;
                    state_next = S_LDB;
                end
            end
            S_LDB: begin
                if (slot_reg != '0 && pos_sat < off_q) begin
                    status_next = ST_ORDER;
                    state_next  = S_FIN;
                end else begin
                    off_we               = 1'b1;
                    valid_next[slot_idx] = 1'b1;
                    ci_next              = '0;
                    state_next           = S_LDW;
                end
            end
            S_LDW: begin
                coef_we = 1'b1;
                ci_next = ci_reg + 1'b1;
                if (ci_reg == 3'(COEFS_PER_STOP - 1)) begin
                    status_next = ST_OK;
                    state_next  = S_FIN;
                end
            end
            // Transform: check both ends first
            S_TR0: begin
                off_raddr  = '0;
                state_next = S_TR1;
            end
            S_TR1: begin
                off_raddr = last_idx;
                ci_next   = '0;
                if (pos_reg <= off_q) begin
                    left_next  = '0;
                    right_next = '0;
                    frac_next  = '0;
                    state_next = S_CRL;
                end else begin
                    state_next = S_TR2;
                end
            end
            S_TR2: begin
                if (pos_reg >= off_q) begin
                    left_next  = last_idx;
                    right_next = CNT_W'(last_idx);
                    frac_next  = '0;
                    state_next = S_CRL;
                end else begin
                    left_next  = last_idx;
                    state_next = S_SLA;
                end
            end
            // Walk left until an offset at or below the position
            S_SLA: begin
                off_raddr  = left_reg;
                state_next = S_SLB;
            end
            S_SLB: begin
                if (left_reg != '0 && pos_reg < off_q) begin
                    left_next  = left_reg - 1'b1;
                    state_next = S_SLA;
                end else begin
                    offl_next  = off_q;
                    right_next = CNT_W'(left_reg) + 1'b1;
                    state_next = S_SRA;
                end
            end
            // Walk right until an offset at or above the position
            S_SRA: begin
                if (right_reg >= n_used) begin
                    rx_next     = px_reg;
                    ry_next     = py_reg;
                    status_next = ST_OK;
                    state_next  = S_FIN;
                end else begin
                    off_raddr  = IDX_W'(right_reg);
                    state_next = S_SRB;
                end
            end
            S_SRB: begin
                if (off_q < pos_reg) begin
                    right_next = right_reg + 1'b1;
                    state_next = S_SRA;
                end else begin
                    offr_next  = off_q;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (offr_reg > offl_reg && pos_reg >= offl_reg) begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    rx_next     = px_reg;
                    ry_next     = py_reg;
                    status_next = ST_OK;
                    state_next  = S_FIN;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    frac_next  = div_rsp.quot[POS_W-1:0];
                    ci_next    = '0;
                    state_next = S_CRL;
                end
            end
            // Interpolate one coefficient: L + floor((R-L)*frac / 2^16)
            S_CRL: begin
                coef_stop  = left_reg;
                coef_raddr = CA_W'(32'(left_reg) * COEFS_PER_STOP + 32'(ci_reg));
                state_next = S_CRR;
            end
            S_CRR: begin
                coef_stop  = IDX_W'(right_reg);
                coef_raddr = CA_W'(32'(IDX_W'(right_reg)) * COEFS_PER_STOP + 32'(ci_reg));
                coefl_next = coef_q;
                state_next = S_CDF;
            end
            S_CDF: begin
                diff_next  = {coef_q[COEF_W-1], coef_q} - {coefl_reg[COEF_W-1], coefl_reg};
                state_next = S_CMUL;
            end
            S_CMUL: begin
                iprod_next = (COEF_W+POS_W+1)'($signed(diff_reg) * $signed({1'b0, frac_reg}));
                state_next = S_CADD;
            end
            S_CADD: begin
                m_next[ci_reg] = coefl_reg + iprod_reg[COEF_W+POS_FRAC-1:POS_FRAC];
                ci_next        = ci_reg + 1'b1;
                if (ci_reg == 3'(COEFS_PER_STOP - 1)) begin
                    row_next   = 1'b0;
                    term_next  = '0;
                    acc_next   = '0;
                    state_next = S_APT;
                end else begin
                    state_next = S_CRL;
                end
            end
            // Row product: a*x + b*y + t*2^F, one term at a time
            S_APT: begin
                if (term_reg == 2'd2) begin
                    acc_next = acc_reg + ($signed({{(ACC_W-COEF_W){row_t[COEF_W-1]}}, row_t})
                               <<< COEF_FRAC_BITS);
                    state_next = S_APS;
                end else begin
                    pprod_next = $signed(mul_a) * $signed(mul_b);
                    state_next = S_APA;
                end
            end
            S_APA: begin
                acc_next   = acc_reg + {{(ACC_W-2*COEF_W){pprod_reg[2*COEF_W-1]}}, pprod_reg};
                term_next  = term_reg + 1'b1;
                state_next = S_APT;
            end
            S_APS: begin
                if (!row_reg) begin
                    rx_next    = sat_val;
                    row_next   = 1'b1;
                    term_next  = '0;
                    acc_next   = '0;
                    state_next = S_APT;
                end else begin
                    ry_next     = sat_val;
                    status_next = ST_OK;
                    state_next  = S_FIN;
                end
            end
            // Hand the result to the output register once it is free
            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    out_x_next   = rx_reg;
                    out_y_next   = ry_reg;
                    out_st_next  = status_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            stop_count_reg <= STOP_COUNT_RESET;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
            off_vld_q_reg  <= 1'b0;
            coef_vld_q_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            m_valid_reg    <= m_valid_next;
            off_vld_q_reg  <= valid_reg[off_raddr];
            coef_vld_q_reg <= valid_reg[coef_stop];
            if (cfg_valid && cfg_ready) begin
                stop_count_reg <= cfg_data;
            end
        end
        slot_reg   <= slot_next;
        pos_reg    <= pos_next;
        cin_reg    <= cin_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        offl_reg   <= offl_next;
        offr_reg   <= offr_next;
        frac_reg   <= frac_next;
        ci_reg     <= ci_next;
        coefl_reg  <= coefl_next;
        diff_reg   <= diff_next;
        iprod_reg  <= iprod_next;
        m_reg      <= m_next;
        row_reg    <= row_next;
        term_reg   <= term_next;
        pprod_reg  <= pprod_next;
        acc_reg    <= acc_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        status_reg <= status_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        out_st_reg <= out_st_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, out_st_reg, out_y_reg, out_x_reg};

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import kap_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic               op;
        logic [3:0]         slot;
        logic [16:0]        pos;
        logic signed [31:0] coef [6];
        logic signed [31:0] px;
        logic signed [31:0] py;
    } xf_item_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [1:0]         status;
    } xf_point_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [4:0]   cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [279:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;

    keyframed_affine_point_transform_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #6 aclk = ~aclk;

    // Shadow copy of the stop table and the stop count
    logic [4:0]         stop_cnt_reg;
    logic [16:0]        stop_off [16];
    logic signed [31:0] stop_mat [16][6];

    xf_point_t expected_points[$];
    int  err_count = 0;
    int  loads_sent = 0;
    int  xforms_sent = 0;
    int  points_checked = 0;
    bit  no_gap_mode = 0;
    bit  hold_req = 0;

    // Floor of (a*x + b*y + t*2^F) / 2^F, saturated to 32 bits
    function automatic logic signed [31:0] mat_row(longint a, longint b, longint t,
                                                   longint x, longint y);
        logic signed [66:0] acc;
        acc = (67'(a) * 67'(x)) + (67'(b) * 67'(y)) + (67'(t) <<< 16);
        acc = acc >>> 16;
        if (acc > 67'sd2147483647) return 32'sh7fffffff;
        if (acc < -67'sd2147483648) return 32'sh80000000;
        return acc[31:0];
    endfunction

    // Expected result of one accepted item; loads update the shadow table
    function automatic xf_point_t transform_point(xf_item_t it);
        xf_point_t r;
        int n, lft, rgt;
        logic [16:0] p;
        longint m [6];
        longint span, frac, l, rv;
        bit ok;
        n = (stop_cnt_reg < 2) ? 2 : (stop_cnt_reg > 16) ? 16 : int'(stop_cnt_reg);
        p = it.pos;
        r.x = 0;
        r.y = 0;
        r.status = ST_OK;
        ok = 1;
        if (it.op == OP_LOAD) begin
            if (p > POS_ONE) p = POS_ONE;
            if (it.slot >= n) begin
                r.status = ST_SLOT;
            end else if (it.slot > 0 && p < stop_off[it.slot - 1]) begin
                r.status = ST_ORDER;
            end else begin
                stop_off[it.slot] = p;
                for (int i = 0; i < 6; i++) stop_mat[it.slot][i] = it.coef[i];
            end
            return r;
        end
        if (p <= stop_off[0]) begin
            for (int i = 0; i < 6; i++) m[i] = stop_mat[0][i];
        end else if (p >= stop_off[n - 1]) begin
            for (int i = 0; i < 6; i++) m[i] = stop_mat[n - 1][i];
        end else begin
            lft = n - 1;
            while (lft > 0 && p < stop_off[lft]) lft--;
            rgt = lft + 1;
            while (rgt < n && stop_off[rgt] < p) rgt++;
            if (rgt < n && stop_off[rgt] > stop_off[lft] && p >= stop_off[lft]) begin
                span = longint'(stop_off[rgt]) - longint'(stop_off[lft]);
                frac = ((longint'(p) - longint'(stop_off[lft])) <<< 16) / span;
                for (int i = 0; i < 6; i++) begin
                    l = stop_mat[lft][i];
                    rv = stop_mat[rgt][i];
                    m[i] = l + (((rv - l) * frac) >>> 16);
                end
            end else begin
                ok = 0;
            end
        end
        if (ok) begin
            r.x = mat_row(m[0], m[2], m[4], it.px, it.py);
            r.y = mat_row(m[1], m[3], m[5], it.px, it.py);
        end else begin
            r.x = it.px;
            r.y = it.py;
        end
        return r;
    endfunction

    // Random coefficient or coordinate: small values mostly, full range sometimes
    function automatic logic signed [31:0] rand_q16();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3:       return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
        endcase
    endfunction

    function automatic xf_item_t load_item(int slot, int pos);
        xf_item_t it;
        it.op = OP_LOAD;
        it.slot = slot[3:0];
        it.pos = pos[16:0];
        for (int i = 0; i < 6; i++) it.coef[i] = rand_q16();
        it.px = $urandom;
        it.py = $urandom;
        return it;
    endfunction

    function automatic xf_item_t point_item(int pos, logic signed [31:0] x,
                                            logic signed [31:0] y);
        xf_item_t it;
        it.op = OP_XFORM;
        it.slot = 4'($urandom);
        it.pos = pos[16:0];
        for (int i = 0; i < 6; i++) it.coef[i] = $urandom;
        it.px = x;
        it.py = y;
        return it;
    endfunction

    function automatic int pick_gap();
        int k;
        if (no_gap_mode) return 0;
        k = $urandom_range(0, 99);
        if (k < 65) return 0;
        if (k < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // One transfer on the input side; valid stays high when no gap follows
    task automatic send_item(xf_item_t it);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= {3'b000, it.py, it.px, it.coef[5], it.coef[4], it.coef[3],
                    it.coef[2], it.coef[1], it.coef[0], it.pos, it.slot};
        do @(posedge aclk); while (!s_tready);
        expected_points.push_back(transform_point(it));
        if (it.op == OP_LOAD) loads_sent++;
        else xforms_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Sender pauses until every expected result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_stop_count(logic [4:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        stop_cnt_reg = v;
        cfg_valid <= 1'b0;
    endtask

    // Edges of the fields and each special case
    task automatic test_directed();
        xf_item_t it;
        write_stop_count(5'd4);
        // transform on the zero table: zero matrix
        send_item(point_item(0, 32'sh7fffffff, 32'sh80000000));
        it = load_item(0, 0);
        it.coef = '{32'sh00010000, 0, 0, 32'sh00010000, 0, 0};
        send_item(it);
        it = load_item(1, 32768);
        it.coef = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                    32'sh7fffffff, 32'sh80000000};
        send_item(it);
        // offset above one is clipped
        send_item(load_item(2, 131071));
        send_item(load_item(3, 65536));
        // slot beyond count, and out of order offset
        send_item(load_item(15, 100));
        send_item(load_item(4, 100));
        send_item(load_item(2, 1000));
        // ends, middle and saturation
        send_item(point_item(0, 32'sh00010000, 32'sh00020000));
        send_item(point_item(65536, -32'sh00010000, 32'sh00030000));
        send_item(point_item(131071, 5, 7));
        send_item(point_item(16384, 32'sh7fffffff, 32'sh7fffffff));
        send_item(point_item(16384, 32'sh80000000, 32'sh80000000));
        send_item(point_item(49152, 32'sh12345678, -32'sh00abcdef));
        // rewrite the offsets (one load out of order), then points between them
        send_item(load_item(0, 10000));
        send_item(load_item(1, 60000));
        send_item(load_item(2, 60000));
        send_item(load_item(1, 30000));
        send_item(load_item(3, 40000));
        send_item(load_item(2, 35000));
        send_item(point_item(50000, 32'sh01020304, 32'sh80000001));
        send_item(point_item(32000, 32'sh00010000, 32'sh00010000));
        send_item(point_item(35000, 3, -3));
    endtask

    // Well-formed stop tables with random content, then points and noise
    task automatic test_random_phase(logic [4:0] cnt, int items);
        int n, off, sent;
        write_stop_count(cnt);
        n = (cnt < 2) ? 2 : (cnt > 16) ? 16 : int'(cnt);
        sent = 0;
        off = $urandom_range(0, 4000);
        for (int s = 0; s < n; s++) begin
            send_item(load_item(s, off));
            sent++;
            off += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 2 * 65536 / n);
            if (off > 65536) off = 65536;
        end
        no_gap_mode = ($urandom_range(0, 3) == 0);
        while (sent < items) begin
            case ($urandom_range(0, 19))
                0:       send_item(load_item($urandom_range(0, 15), $urandom_range(0, 131071)));
                1:       send_item(load_item($urandom_range(0, n - 1),
                                             $urandom_range(0, 65536)));
                2:       send_item(point_item($urandom_range(0, 131071), $urandom, $urandom));
                default: send_item(point_item($urandom_range(0, 65536), rand_q16(), rand_q16()));
            endcase
            sent++;
        end
        no_gap_mode = 0;
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_output_stall();
        hold_req = 1;
        no_gap_mode = 1;
        for (int i = 0; i < 20; i++)
            send_item(point_item($urandom_range(0, 65536), rand_q16(), rand_q16()));
        no_gap_mode = 0;
        drain();
    endtask

    // Result checker and receiver pacing
    initial begin : result_side
        xf_point_t e;
        logic signed [31:0] ax, ay;
        logic [1:0] ast;
        int hold_left, k;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                ax = m_tdata[31:0];
                ay = m_tdata[63:32];
                ast = m_tdata[65:64];
                if (expected_points.size() == 0) begin
                    $error("result with nothing expected: x=%0d y=%0d status=%0d", ax, ay, ast);
                    err_count++;
                end else begin
                    e = expected_points.pop_front();
                    points_checked++;
                    if (ax !== e.x) begin
                        $error("out_x: expected %0d, got %0d", e.x, ax);
                        err_count++;
                    end
                    if (ay !== e.y) begin
                        $error("out_y: expected %0d, got %0d", e.y, ay);
                        err_count++;
                    end
                    if (ast !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, ast);
                        err_count++;
                    end
                end
            end
            if (hold_req && hold_left == 0) begin
                hold_req = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                k = $urandom_range(0, 99);
                if (k < 70) m_tready <= 1'b1;
                else if (k < 97) m_tready <= 1'b0;
                else begin
                    m_tready <= 1'b0;
                    hold_left = $urandom_range(10, 60);
                end
            end
        end
    end

    // Watchdog: cycles without any transfer
    initial begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || !aresetn)
                idle = 0;
            else
                idle++;
            if (idle >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin : main_seq
        logic [4:0] counts [8];
        counts = '{5'd2, 5'd16, 5'd31, 5'd0, 5'd1, 5'd7, 5'd12, 5'd3};
        stop_cnt_reg = STOP_COUNT_RESET;
        for (int s = 0; s < 16; s++) begin
            stop_off[s] = '0;
            for (int i = 0; i < 6; i++) stop_mat[s][i] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_output_stall();
        foreach (counts[i]) test_random_phase(counts[i], 225);
        drain();
        if (expected_points.size() != 0) begin
            $error("%0d results never arrived", expected_points.size());
            err_count++;
        end
        $display("covered %0d stop loads and %0d point transforms, %0d results checked",
                 loads_sent, xforms_sent, points_checked);
        $display("stop counts from 0 to 31 used, with an output stall and idle pauses");
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
